FILE: rtl/core/rcpc_pkg.sv
package rcpc_pkg;

    localparam int CHANNELS = 4;

    localparam int WIDTH_W = 16;
    localparam int AGE_W   = 24;
    localparam int RECIP_W = 20;
    localparam int DEAD_W  = 15;
    localparam int NORM_W  = 16;
    localparam int PROD_W  = WIDTH_W + RECIP_W;
    localparam int CFG_W   = 24;
    localparam int INDEX_W = 3;

    localparam logic [WIDTH_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [AGE_W-1:0]   AGE_MAX   = 24'hFFFFFF;
    localparam logic [DEAD_W-1:0]  Q14_ONE   = 15'd16384;

    localparam logic [INDEX_W-1:0] REG_VALID_LOW   = 3'd0;
    localparam logic [INDEX_W-1:0] REG_VALID_HIGH  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_NEUTRAL     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SPAN_RECIP  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_DEADBAND    = 3'd4;
    localparam logic [INDEX_W-1:0] REG_TIMEOUT     = 3'd5;

    localparam logic [WIDTH_W-1:0] VALID_LOW_RST  = 16'd800;
    localparam logic [WIDTH_W-1:0] VALID_HIGH_RST = 16'd2200;
    localparam logic [WIDTH_W-1:0] NEUTRAL_RST    = 16'd1500;
    localparam logic [RECIP_W-1:0] SPAN_RECIP_RST = 20'd33554;
    localparam logic [DEAD_W-1:0]  DEADBAND_RST   = 15'd819;
    localparam logic [AGE_W-1:0]   TIMEOUT_RST    = 24'd100000;

    typedef struct packed {
        logic [WIDTH_W-1:0] valid_low_us;
        logic [WIDTH_W-1:0] valid_high_us;
        logic [WIDTH_W-1:0] neutral_us;
        logic [RECIP_W-1:0] span_reciprocal;
        logic [DEAD_W-1:0]  deadband_q14;
        logic [AGE_W-1:0]   timeout_us;
    } cfg_t;

endpackage

FILE: rtl/core/rcpc_capture.sv
module rcpc_capture (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              level,
    input  rcpc_pkg::cfg_t                    cfg,
    output logic [rcpc_pkg::WIDTH_W-1:0]      held_s1,
    output logic                              fresh_s1
);
    import rcpc_pkg::*;

    logic               prev_reg;
    logic               prev_next;
    logic               rise_reg;
    logic               rise_next;
    logic [WIDTH_W-1:0] count_reg;
    logic [WIDTH_W-1:0] count_next;
    logic [WIDTH_W-1:0] held_reg;
    logic [WIDTH_W-1:0] held_next;
    logic [AGE_W-1:0]   age_reg;
    logic [AGE_W-1:0]   age_next;
    logic [WIDTH_W-1:0] held_s1_reg;
    logic               fresh_s1_reg;
    logic               taken;

    always_comb
    begin
        rise_next  = rise_reg;
        count_next = count_reg;
        held_next  = held_reg;
        taken      = 1'b0;
        if (level && !prev_reg)
        begin
            rise_next  = 1'b1;
            count_next = {{(WIDTH_W-1){1'b0}}, 1'b1};
        end
        else if (level)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (prev_reg && rise_reg)
        begin
            if (count_reg != COUNT_MAX && count_reg >= cfg.valid_low_us
                && count_reg <= cfg.valid_high_us)
            begin
                held_next = count_reg;
                taken     = 1'b1;
            end
            rise_next = 1'b0;
        end
        if (taken)
        begin
            age_next = '0;
        end
        else if (age_reg != AGE_MAX)
        begin
            age_next = age_reg + 1'b1;
        end
        else
        begin
            age_next = age_reg;
        end
        prev_next = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b0;
            rise_reg  <= 1'b0;
            count_reg <= '0;
            held_reg  <= '0;
            age_reg   <= '0;
        end
        else if (accept)
        begin
            prev_reg  <= prev_next;
            rise_reg  <= rise_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_s1_reg  <= held_next;
            fresh_s1_reg <= (held_next != '0) && (age_next < cfg.timeout_us);
        end
    end

    assign held_s1  = held_s1_reg;
    assign fresh_s1 = fresh_s1_reg;

endmodule

FILE: rtl/core/rcpc_norm.sv
module rcpc_norm (
    input  logic                              clk,
    input  logic                              en,
    input  logic [rcpc_pkg::WIDTH_W-1:0]      held,
    input  rcpc_pkg::cfg_t                    cfg,
    output logic signed [rcpc_pkg::NORM_W-1:0] norm
);
    import rcpc_pkg::*;

    logic [WIDTH_W-1:0]       mag;
    logic                     neg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic [PROD_W:0]          rounded;
    logic [PROD_W-10:0]       q_full;
    logic [DEAD_W-1:0]        q_clamp;
    logic signed [NORM_W-1:0] norm_next;
    logic signed [NORM_W-1:0] norm_reg;

    always_comb
    begin
        if (held >= cfg.neutral_us)
        begin
            mag = held - cfg.neutral_us;
            neg = 1'b0;
        end
        else
        begin
            mag = cfg.neutral_us - held;
            neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(mag) * PROD_W'(cfg.span_reciprocal);
            neg_reg  <= neg;
            zero_reg <= (held == '0);
        end
    end

    always_comb
    begin
        rounded = {1'b0, prod_reg} + (PROD_W+1)'(512);
        q_full  = rounded[PROD_W:10];
        if (q_full > (PROD_W-9)'(Q14_ONE))
        begin
            q_clamp = Q14_ONE;
        end
        else
        begin
            q_clamp = q_full[DEAD_W-1:0];
        end
        if (zero_reg || q_clamp < cfg.deadband_q14)
        begin
            norm_next = '0;
        end
        else if (neg_reg)
        begin
            norm_next = -$signed({1'b0, q_clamp});
        end
        else
        begin
            norm_next = $signed({1'b0, q_clamp});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

FILE: rtl/core/rc_pwm_pulse_capture.sv
// Four-channel RC servo pulse decoder. Each request is one microsecond tick carrying the
// four pin levels (bit 0 left, bit 1 right, bit 2 mode, bit 3 arm), and each request
// produces exactly one result with the held widths, the normalized Q14 values, the
// freshness mask and link_ok as they stand after that tick. One request is taken every
// clock cycle while the output is not stalled; a result passes through the capture
// register, the normalization multiplier register and the output register of the four
// channel lanes. A stalled result holds the whole pipeline and stalls the input. The
// user must write configuration through cfg_we, cfg_index and cfg_data only while no
// request is in flight; the block itself does not enforce this.
module rc_pwm_pulse_capture (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rcpc_pkg::CHANNELS-1:0]      pin_levels,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rcpc_pkg::WIDTH_W-1:0]       width_left,
    output logic [rcpc_pkg::WIDTH_W-1:0]       width_right,
    output logic [rcpc_pkg::WIDTH_W-1:0]       width_mode,
    output logic [rcpc_pkg::WIDTH_W-1:0]       width_arm,
    output logic signed [rcpc_pkg::NORM_W-1:0] norm_left,
    output logic signed [rcpc_pkg::NORM_W-1:0] norm_right,
    output logic signed [rcpc_pkg::NORM_W-1:0] norm_mode,
    output logic signed [rcpc_pkg::NORM_W-1:0] norm_arm,
    output logic [rcpc_pkg::CHANNELS-1:0]      fresh_mask,
    output logic                               link_ok,
    input  logic                               cfg_we,
    input  logic [rcpc_pkg::INDEX_W-1:0]       cfg_index,
    input  logic [rcpc_pkg::CFG_W-1:0]         cfg_data
);
    import rcpc_pkg::*;

    cfg_t                     cfg_reg;
    logic                     accept;
    logic                     en;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     out_valid_reg;
    logic [WIDTH_W-1:0]       held_s1 [CHANNELS];
    logic                     fresh_s1 [CHANNELS];
    logic [WIDTH_W-1:0]       held_s2_reg [CHANNELS];
    logic [CHANNELS-1:0]      fresh_s2_reg;
    logic [WIDTH_W-1:0]       width_reg [CHANNELS];
    logic [CHANNELS-1:0]      fresh_reg;
    logic                     link_reg;
    logic signed [NORM_W-1:0] norm_q [CHANNELS];

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.valid_low_us    <= VALID_LOW_RST;
            cfg_reg.valid_high_us   <= VALID_HIGH_RST;
            cfg_reg.neutral_us      <= NEUTRAL_RST;
            cfg_reg.span_reciprocal <= SPAN_RECIP_RST;
            cfg_reg.deadband_q14    <= DEADBAND_RST;
            cfg_reg.timeout_us      <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VALID_LOW:  cfg_reg.valid_low_us    <= cfg_data[WIDTH_W-1:0];
                REG_VALID_HIGH: cfg_reg.valid_high_us   <= cfg_data[WIDTH_W-1:0];
                REG_NEUTRAL:    cfg_reg.neutral_us      <= cfg_data[WIDTH_W-1:0];
                REG_SPAN_RECIP: cfg_reg.span_reciprocal <= cfg_data[RECIP_W-1:0];
                REG_DEADBAND:   cfg_reg.deadband_q14    <= cfg_data[DEAD_W-1:0];
                REG_TIMEOUT:    cfg_reg.timeout_us      <= cfg_data[AGE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        rcpc_capture u_capture (
            .clk      (clk),
            .rst_n    (rst_n),
            .accept   (accept),
            .level    (pin_levels[c]),
            .cfg      (cfg_reg),
            .held_s1  (held_s1[c]),
            .fresh_s1 (fresh_s1[c])
        );

        rcpc_norm u_norm (
            .clk  (clk),
            .en   (en),
            .held (held_s1[c]),
            .cfg  (cfg_reg),
            .norm (norm_q[c])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                held_s2_reg[c]  <= held_s1[c];
                fresh_s2_reg[c] <= fresh_s1[c];
                width_reg[c]    <= held_s2_reg[c];
                fresh_reg[c]    <= fresh_s2_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            link_reg <= fresh_s2_reg[0] && fresh_s2_reg[1] && fresh_s2_reg[3];
        end
    end

    assign out_valid   = out_valid_reg;
    assign width_left  = width_reg[0];
    assign width_right = width_reg[1];
    assign width_mode  = width_reg[2];
    assign width_arm   = width_reg[3];
    assign norm_left   = norm_q[0];
    assign norm_right  = norm_q[1];
    assign norm_mode   = norm_q[2];
    assign norm_arm    = norm_q[3];
    assign fresh_mask  = fresh_reg;
    assign link_ok     = link_reg;

    a_norm_needs_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (width_left == '0) |-> (norm_left == '0))
        else $error("left norm nonzero without a held width");

    a_fresh_needs_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fresh_mask[1] |-> (width_right != '0))
        else $error("right channel fresh without a held width");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (norm_arm <= 16'sd16384) && (norm_arm >= -16'sd16384))
        else $error("arm norm outside plus or minus one");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted request lost at the first stage");

endmodule
